@@ rtl/scs_pkg.sv @@
package scs_pkg;

  // field and accumulator widths
  localparam int SAMPLE_W       = 24;
  localparam int CFG_W          = 24;
  localparam int SUM_W          = 40;
  localparam int SQ_W           = 64;
  localparam int SLOPE_W        = 32;
  localparam int DVD_W          = 64;
  localparam int DIV_W          = 25;
  localparam int RAD_W          = 64;
  localparam int ROOT_W         = 32;
  localparam int MAX_PIXELS_DEF = 65536;

  // register indexes
  localparam logic [1:0] REG_SCALE_MODE = 2'd0;
  localparam logic [1:0] REG_MASK_EN    = 2'd1;
  localparam logic [1:0] REG_MASK_VAL   = 2'd2;
  localparam logic [1:0] REG_FACTOR     = 2'd3;

  // scale modes
  localparam logic [1:0] MODE_TRUNC  = 2'd0;
  localparam logic [1:0] MODE_MINMAX = 2'd1;
  localparam logic [1:0] MODE_SIGMA  = 2'd2;
  localparam logic [1:0] MODE_FIXED  = 2'd3;

  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 24'sh7FFFFF;
  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = -24'sh800000;
  localparam logic signed [SAMPLE_W-1:0] TRUNC_TOP  = 24'sd65280;
  localparam logic [CFG_W-1:0]           FACTOR_RST = 24'd65536;
  localparam logic [7:0]                 PIX_MAX    = 8'd255;
  localparam logic [SLOPE_W-1:0]         SLOPE_NUM  = 32'hFF000000;

  // bound computation steps
  typedef enum logic [3:0] {
    BS_NONE, BS_ZERO, BS_MINMAX, BS_MDIV, BS_MEAN, BS_P1, BS_P2, BS_P3,
    BS_ADIV, BS_TN, BS_ROOT, BS_CLIP, BS_SDIV, BS_SLOPE
  } bstep_t;

  typedef struct packed {
    logic   load;
    logic   clear;
    logic   mul;
    logic   accum;
    logic   emit;
    bstep_t step;
  } scs_cmd_t;

  typedef struct packed {
    logic [1:0] scale_mode;
    logic       item_conv;
    logic       item_last;
    logic       cnt_zero;
    logic       out_busy;
    logic       div_done;
    logic       root_done;
    logic       range_pos;
  } scs_stat_t;

endpackage

@@ rtl/scs_div.sv @@
module scs_div import scs_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [DVD_W-1:0] dividend,
  input  logic [DIV_W-1:0] divisor,
  output logic             done,
  output logic [DVD_W-1:0] quot,
  output logic [DIV_W-1:0] rem
);

  localparam int CNT_W = $clog2(DVD_W);
  localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(DVD_W - 1);

  logic             busy_r, done_r;
  logic [CNT_W-1:0] cnt_r;
  logic [DVD_W-1:0] q_r;
  logic [DIV_W-1:0] rem_r, dsr_r;
  logic [DIV_W:0]   shifted, diff;
  logic             ge;

  // one restoring step per cycle
  always_comb begin
    shifted = {rem_r, q_r[DVD_W-1]};
    diff    = shifted - {1'b0, dsr_r};
    ge      = (shifted >= {1'b0, dsr_r});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == LAST_STEP) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q_r   <= dividend;
      rem_r <= '0;
      dsr_r <= divisor;
    end else if (busy_r) begin
      q_r   <= {q_r[DVD_W-2:0], ge};
      rem_r <= ge ? diff[DIV_W-1:0] : shifted[DIV_W-1:0];
    end
  end

  assign done = done_r;
  assign quot = q_r;
  assign rem  = rem_r;

endmodule

@@ rtl/scs_root.sv @@
module scs_root import scs_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [RAD_W-1:0]  radicand,
  output logic              done,
  output logic [ROOT_W-1:0] root
);

  localparam int CNT_W = $clog2(ROOT_W);
  localparam int REM_W = ROOT_W + 2;
  localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(ROOT_W - 1);

  logic              busy_r, done_r;
  logic [CNT_W-1:0]  cnt_r;
  logic [RAD_W-1:0]  v_r;
  logic [REM_W-1:0]  rem_r;
  logic [ROOT_W-1:0] root_r;
  logic [REM_W+1:0]  shifted, trial, diff;
  logic              ge;

  // two radicand bits per cycle, one root bit
  always_comb begin
    shifted = {rem_r, v_r[RAD_W-1 -: 2]};
    trial   = {2'b00, root_r, 2'b01};
    diff    = shifted - trial;
    ge      = (shifted >= trial);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == LAST_STEP) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      v_r    <= radicand;
      rem_r  <= '0;
      root_r <= '0;
    end else if (busy_r) begin
      v_r    <= {v_r[RAD_W-3:0], 2'b00};
      rem_r  <= ge ? diff[REM_W-1:0] : shifted[REM_W-1:0];
      root_r <= {root_r[ROOT_W-2:0], ge};
    end
  end

  assign done = done_r;
  assign root = root_r;

endmodule

@@ rtl/scs_dp.sv @@
module scs_dp import scs_pkg::*; #(
  parameter int MAX_PIXELS = MAX_PIXELS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  scs_cmd_t            cmd,
  output scs_stat_t           stat,
  input  logic [SAMPLE_W-1:0] in_tdata,
  input  logic                in_tuser,
  input  logic                in_tlast,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_addr,
  input  logic [CFG_W-1:0]    cfg_wdata,
  output logic                out_tvalid,
  input  logic                out_tready,
  output logic [7:0]          out_tdata,
  output logic                out_tuser
);

  localparam int CW = $clog2(MAX_PIXELS + 1);
  localparam logic [CW-1:0] CNT_MAX = CW'(MAX_PIXELS);

  // configuration
  logic [1:0]                 mode_cfg_r;
  logic                       mask_en_r;
  logic signed [SAMPLE_W-1:0] mask_val_r;
  logic [CFG_W-1:0]           factor_r;

  // current item
  logic                       conv_r, last_r;
  logic signed [SAMPLE_W-1:0] s_r;
  logic signed [SAMPLE_W:0]   d_r;
  logic signed [SAMPLE_W-1:0] in_sample;

  // statistics and bounds
  logic signed [SAMPLE_W-1:0] low_r, high_r, floor_r, lo_r, hi_r, m_r;
  logic signed [SUM_W-1:0]    sum_r;
  logic [SQ_W-1:0]            sq_r;
  logic [CW-1:0]              cnt_r, r_r;
  logic [SLOPE_W-1:0]         slope_r;

  // products
  logic signed [2*SAMPLE_W-1:0] sqp_r;
  logic signed [2*SAMPLE_W:0]   p3_r;
  logic [SAMPLE_W+SLOPE_W-1:0]  ps_r;
  logic [2*SAMPLE_W-1:0]        mm_r;
  logic signed [SAMPLE_W+CW:0]  mn_r, mr;
  logic [SQ_W-1:0]              mmn_r, mr2_r;
  logic [2*CW-1:0]              rr_r, tn_r;

  // output register
  logic       out_valid_r, empty_r;
  logic [7:0] pix_r;

  // shared divider and square root unit
  logic             div_start, div_done, root_start, root_done;
  logic [DVD_W-1:0] div_dvd, div_quot;
  logic [DIV_W-1:0] div_dsr, div_rem;
  logic [RAD_W-1:0] variance_v;
  logic [ROOT_W-1:0] root_val;

  logic signed [SQ_W-1:0]   sum64, r64, mq, mean_full, mr64;
  logic [SQ_W-1:0]          a_v;
  logic signed [SAMPLE_W:0] range_s;
  logic signed [35:0]       m36, sd2, lo_c, hi_c;
  logic                     skip;
  logic [7:0]               pix_v;
  logic                     empty_v;
  logic [15:0]              ru;
  logic [SAMPLE_W-1:0]      hi3;
  logic [SLOPE_W-1:0]       vs;

  assign in_sample = $signed(in_tdata);

  // config writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_cfg_r <= MODE_TRUNC;
      mask_en_r  <= 1'b0;
      mask_val_r <= '0;
      factor_r   <= FACTOR_RST;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_SCALE_MODE: mode_cfg_r <= cfg_wdata[1:0];
        REG_MASK_EN:    mask_en_r  <= cfg_wdata[0];
        REG_MASK_VAL:   mask_val_r <= $signed(cfg_wdata);
        REG_FACTOR:     factor_r   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // item capture and per-item products
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      s_r    <= in_sample;
      d_r    <= (SAMPLE_W+1)'(in_sample) - (SAMPLE_W+1)'(floor_r);
      conv_r <= in_tuser;
      last_r <= in_tlast;
    end
    if (cmd.mul) begin
      sqp_r <= s_r * s_r;
      p3_r  <= s_r * $signed({1'b0, factor_r});
      ps_r  <= d_r[SAMPLE_W-1:0] * slope_r;
    end
  end

  // samples left out of the statistics
  always_comb begin
    if (mode_cfg_r == MODE_SIGMA) skip = (s_r == '0);
    else                          skip = mask_en_r && (s_r == mask_val_r);
  end

  // statistics accumulators
  always_ff @(posedge clk) begin
    if (!rst_n || cmd.clear) begin
      low_r  <= SAMPLE_MAX;
      high_r <= SAMPLE_MIN;
      sum_r  <= '0;
      sq_r   <= '0;
      cnt_r  <= '0;
    end else if (cmd.accum && !skip && (cnt_r < CNT_MAX)) begin
      if (s_r < low_r)  low_r  <= s_r;
      if (s_r > high_r) high_r <= s_r;
      sum_r <= sum_r + SUM_W'(s_r);
      sq_r  <= sq_r + SQ_W'($unsigned(sqp_r));
      cnt_r <= cnt_r + 1'b1;
    end
  end

  // bound arithmetic
  always_comb begin
    sum64      = SQ_W'(sum_r);
    r64        = sum64 - SQ_W'(mn_r);
    mq         = $signed(div_quot);
    mean_full  = (sum_r < 0) ? (-mq - SQ_W'(div_rem != '0)) : mq;
    mr         = m_r * $signed({1'b0, r_r});
    mr64       = SQ_W'(mr);
    a_v        = sq_r - mmn_r - mr2_r;
    range_s    = (SAMPLE_W+1)'(hi_r) - (SAMPLE_W+1)'(lo_r);
    m36        = 36'(m_r);
    sd2        = $signed({3'b000, root_val, 1'b0});
    lo_c       = m36 - sd2;
    hi_c       = m36 + sd2;
    if (tn_r < rr_r) variance_v = (div_quot != '0) ? div_quot - 1'b1 : '0;
    else             variance_v = div_quot;
  end

  // divider operand select
  always_comb begin
    div_start = 1'b0;
    div_dvd   = a_v;
    div_dsr   = DIV_W'(cnt_r);
    case (cmd.step)
      BS_MDIV: begin
        div_start = 1'b1;
        div_dvd   = (sum_r < 0) ? $unsigned(-sum64) : $unsigned(sum64);
      end
      BS_ADIV: div_start = 1'b1;
      BS_SDIV: begin
        div_start = 1'b1;
        div_dvd   = DVD_W'(SLOPE_NUM) + DVD_W'($unsigned(range_s)) - 1'b1;
        div_dsr   = $unsigned(range_s);
      end
      default: ;
    endcase
  end

  assign root_start = (cmd.step == BS_ROOT);

  // bound steps
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      floor_r <= '0;
      slope_r <= '0;
    end else begin
      unique case (cmd.step)
        BS_ZERO: begin
          floor_r <= '0;
          slope_r <= '0;
        end
        BS_SLOPE: begin
          floor_r <= lo_r;
          slope_r <= div_quot[SLOPE_W-1:0];
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (cmd.step)
      BS_MINMAX: begin
        lo_r <= low_r;
        hi_r <= high_r;
      end
      BS_MEAN: m_r <= mean_full[SAMPLE_W-1:0];
      BS_P1: begin
        mm_r <= m_r * m_r;
        mn_r <= m_r * $signed({1'b0, cnt_r});
      end
      BS_P2: begin
        mmn_r <= SQ_W'(mm_r) * SQ_W'(cnt_r);
        r_r   <= r64[CW-1:0];
      end
      BS_P3: begin
        mr2_r <= {mr64[SQ_W-2:0], 1'b0};
        rr_r  <= r_r * r_r;
      end
      BS_TN: tn_r <= div_rem[CW-1:0] * cnt_r;
      BS_CLIP: begin
        lo_r <= (lo_c > 36'(low_r))  ? lo_c[SAMPLE_W-1:0] : low_r;
        hi_r <= (hi_c < 36'(high_r)) ? hi_c[SAMPLE_W-1:0] : high_r;
      end
      default: ;
    endcase
  end

  scs_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dvd),
    .divisor  (div_dsr),
    .done     (div_done),
    .quot     (div_quot),
    .rem      (div_rem)
  );

  scs_root u_root (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (root_start),
    .radicand (variance_v),
    .done     (root_done),
    .root     (root_val)
  );

  // result byte for a convert item
  always_comb begin
    pix_v   = '0;
    empty_v = 1'b0;
    ru      = s_r[15:0] + 16'd128;
    hi3     = p3_r[2*SAMPLE_W-1:SAMPLE_W];
    vs      = ps_r[SAMPLE_W+SLOPE_W-1:SAMPLE_W];
    case (mode_cfg_r)
      MODE_TRUNC: begin
        if (s_r < 0)              pix_v = '0;
        else if (s_r > TRUNC_TOP) pix_v = PIX_MAX;
        else                      pix_v = ru[15:8];
      end
      MODE_FIXED: begin
        if (p3_r[2*SAMPLE_W])  pix_v = '0;
        else if (hi3 > 24'd255) pix_v = PIX_MAX;
        else                   pix_v = hi3[7:0];
      end
      default: begin
        if (slope_r == '0) begin
          empty_v = 1'b1;
        end else if (d_r[SAMPLE_W]) begin
          pix_v = '0;
        end else if (vs > 32'd255) begin
          pix_v = PIX_MAX;
        end else begin
          pix_v = vs[7:0];
        end
      end
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      pix_r   <= pix_v;
      empty_r <= empty_v;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = pix_r;
  assign out_tuser  = empty_r;

  assign stat.scale_mode = mode_cfg_r;
  assign stat.item_conv  = conv_r;
  assign stat.item_last  = last_r;
  assign stat.cnt_zero   = (cnt_r == '0);
  assign stat.out_busy   = out_valid_r && !out_tready;
  assign stat.div_done   = div_done;
  assign stat.root_done  = root_done;
  assign stat.range_pos  = (range_s > 0);

endmodule

@@ rtl/scs_ctrl.sv @@
module scs_ctrl import scs_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_tvalid,
  output logic      in_tready,
  output scs_cmd_t  cmd,
  input  scs_stat_t stat
);

  typedef enum logic [3:0] {
    S_IDLE, S_MUL, S_FIN, S_BND, S_MWAIT, S_P1, S_P2, S_P3,
    S_ADIV, S_AWAIT, S_VAR, S_RWAIT, S_RANGE, S_SWAIT
  } state_t;

  state_t state_r, state_nxt;
  logic   fresh_r, fresh_nxt;

  // sequencing and commands
  always_comb begin
    state_nxt = state_r;
    fresh_nxt = fresh_r;
    cmd       = '0;
    cmd.step  = BS_NONE;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          state_nxt = S_MUL;
        end
      end
      S_MUL: begin
        cmd.mul = 1'b1;
        if (!stat.item_conv && fresh_r) begin
          cmd.clear = 1'b1;
          fresh_nxt = 1'b0;
        end
        state_nxt = S_FIN;
      end
      S_FIN: begin
        if (stat.item_conv) begin
          if (!stat.out_busy) begin
            cmd.emit  = 1'b1;
            state_nxt = S_IDLE;
          end
        end else begin
          cmd.accum = 1'b1;
          if (stat.item_last) begin
            fresh_nxt = 1'b1;
            state_nxt = S_BND;
          end else begin
            state_nxt = S_IDLE;
          end
        end
      end
      S_BND: begin
        if (stat.cnt_zero) begin
          cmd.step  = BS_ZERO;
          state_nxt = S_IDLE;
        end else if (stat.scale_mode != MODE_SIGMA) begin
          cmd.step  = BS_MINMAX;
          state_nxt = S_RANGE;
        end else begin
          cmd.step  = BS_MDIV;
          state_nxt = S_MWAIT;
        end
      end
      S_MWAIT: begin
        if (stat.div_done) begin
          cmd.step  = BS_MEAN;
          state_nxt = S_P1;
        end
      end
      S_P1: begin
        cmd.step  = BS_P1;
        state_nxt = S_P2;
      end
      S_P2: begin
        cmd.step  = BS_P2;
        state_nxt = S_P3;
      end
      S_P3: begin
        cmd.step  = BS_P3;
        state_nxt = S_ADIV;
      end
      S_ADIV: begin
        cmd.step  = BS_ADIV;
        state_nxt = S_AWAIT;
      end
      S_AWAIT: begin
        if (stat.div_done) begin
          cmd.step  = BS_TN;
          state_nxt = S_VAR;
        end
      end
      S_VAR: begin
        cmd.step  = BS_ROOT;
        state_nxt = S_RWAIT;
      end
      S_RWAIT: begin
        if (stat.root_done) begin
          cmd.step  = BS_CLIP;
          state_nxt = S_RANGE;
        end
      end
      S_RANGE: begin
        if (stat.range_pos) begin
          cmd.step  = BS_SDIV;
          state_nxt = S_SWAIT;
        end else begin
          cmd.step  = BS_ZERO;
          state_nxt = S_IDLE;
        end
      end
      S_SWAIT: begin
        if (stat.div_done) begin
          cmd.step  = BS_SLOPE;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      fresh_r <= 1'b1;
    end else begin
      state_r <= state_nxt;
      fresh_r <= fresh_nxt;
    end
  end

  assign in_tready = (state_r == S_IDLE);

endmodule

@@ rtl/sample_to_byte_contrast_stretch_core.sv @@
// Signed Q16.8 sample to byte converter with four scaling modes.
// Input stream: in_tdata carries the sample, in_tuser selects gather (0)
// or convert (1), in_tlast marks the final gather beat of a pass.
// Output stream: one beat per convert beat, out_tdata the byte and
// out_tuser the empty-range flag. Gather beats produce no output.
// Configuration is written through cfg_we/cfg_addr/cfg_wdata while idle.
// Each input beat is captured, multiplied, then accumulated or turned into
// a result; in_tready is high only when the sequencer is idle. A convert
// result reaches the output register after the capture and product registers.
// The final gather beat of a pass starts the bound computation on a shared
// 64-step restoring divider and, in two-sigma mode, a 32-step square root unit.
// If the receiver stalls, the result is held and one more convert beat is
// accepted; that beat's result waits until the output register drains.
// Synchronous reset clears statistics and bounds, empties the output and
// restores register defaults (scale factor 1.0, truncate mode).
module sample_to_byte_contrast_stretch_core import scs_pkg::*; #(
  parameter int MAX_PIXELS = MAX_PIXELS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  input  logic [SAMPLE_W-1:0] in_tdata,   // [23:0] sample
  input  logic                in_tuser,   // [0] mode
  input  logic                in_tlast,
  output logic                out_tvalid,
  input  logic                out_tready,
  output logic [7:0]          out_tdata,  // [7:0] pixel
  output logic                out_tuser,  // [0] range_empty
  input  logic                cfg_we,
  input  logic [1:0]          cfg_addr,
  input  logic [CFG_W-1:0]    cfg_wdata
);

  scs_cmd_t  cmd;
  scs_stat_t stat;

  scs_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .cmd       (cmd),
    .stat      (stat)
  );

  scs_dp #(.MAX_PIXELS(MAX_PIXELS)) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .stat       (stat),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule

@@ rtl/scs_chk.sv @@
module scs_chk (
  input logic       clk,
  input logic       rst_n,
  input logic       in_tvalid,
  input logic       in_tready,
  input logic       in_tuser,
  input logic       out_tvalid,
  input logic       out_tready,
  input logic [7:0] out_tdata,
  input logic       out_tuser
);

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("stalled output beat changed");

  // in_tready drops right after every accepted beat
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("ready high right after an accepted beat");

  // no result beat starts just after a gather beat is accepted
  a_gather_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && !in_tuser |=> !$rose(out_tvalid) ##1 !$rose(out_tvalid))
    else $error("output beat from a gather beat");

  // an empty range always carries a zero byte
  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tdata == 8'd0)
    else $error("empty range with nonzero byte");

  // output is empty after reset
  a_reset: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("output valid after reset");

endmodule

bind sample_to_byte_contrast_stretch_core scs_chk u_scs_chk (.*);

@@ test/tb_top.sv @@
`timescale 1ns / 100ps

module tb_top;
  import scs_pkg::*;

  typedef longint unsigned u64_t;

  typedef struct {
    bit                          conv;
    logic signed [SAMPLE_W-1:0]  s;
    bit                          lst;
  } beat_t;

  typedef struct {
    logic [7:0] pixel;
    logic       empty;
  } pix_t;

  localparam int CAP = MAX_PIXELS_DEF;

  logic                clk;
  logic                rst_n = 1'b0;
  logic                in_tvalid = 1'b0;
  logic                in_tready;
  logic [SAMPLE_W-1:0] in_tdata = '0;
  logic                in_tuser = 1'b0;
  logic                in_tlast = 1'b0;
  logic                out_tvalid;
  logic                out_tready = 1'b0;
  logic [7:0]          out_tdata;
  logic                out_tuser;
  logic                cfg_we = 1'b0;
  logic [1:0]          cfg_addr = '0;
  logic [CFG_W-1:0]    cfg_wdata = '0;

  sample_to_byte_contrast_stretch_core i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  beat_t beat_q[$];
  pix_t  pix_q[$];
  beat_t cur_beat;
  int    errors = 0;
  int    fed = 0;
  bit    calm = 0;
  bit    hold_req = 0;
  int    stall_left = 0;
  bit    hold_off = 0;

  // shadow of the configuration registers
  logic [1:0] r_mode = MODE_TRUNC;
  bit         r_mask_en = 0;
  int         r_mask_val = 0;
  u64_t       r_factor = FACTOR_RST;

  // shadow of the statistics and bounds
  int    lo_seen = 8388607;
  int    hi_seen = -8388608;
  longint acc_sum = 0;
  u64_t  acc_sq = 0;
  int    n_counted = 0;
  longint st_floor = 0;
  u64_t  st_slope = 0;
  bit    fresh = 1;

  function automatic u64_t isqrt(u64_t v);
    u64_t r, b;
    r = 0;
    b = u64_t'(1) << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // stretch floor and slope from the finished gather pass
  function automatic void derive_bounds();
    longint lo, hi, rng, nn, m, r;
    u64_t a, q, t, vr, sd;
    st_floor = 0;
    st_slope = 0;
    if (n_counted == 0) return;
    lo = lo_seen;
    hi = hi_seen;
    if (r_mode == MODE_SIGMA) begin
      nn = n_counted;
      m = acc_sum / nn;
      if (acc_sum % nn != 0 && acc_sum < 0) m = m - 1;
      r = acc_sum - m * nn;
      a = acc_sq - u64_t'(m * m) * u64_t'(nn) - u64_t'(2) * u64_t'(m) * u64_t'(r);
      q = a / u64_t'(nn);
      t = a % u64_t'(nn);
      vr = q;
      if (t * u64_t'(nn) < u64_t'(r) * u64_t'(r)) vr = (q > 0) ? q - 1 : 0;
      sd = isqrt(vr);
      if (m - 2 * longint'(sd) > lo) lo = m - 2 * longint'(sd);
      if (m + 2 * longint'(sd) < hi) hi = m + 2 * longint'(sd);
    end
    rng = hi - lo;
    if (rng <= 0) return;
    st_floor = lo;
    st_slope = ((u64_t'(255) << 24) + u64_t'(rng) - 1) / u64_t'(rng);
  endfunction

  function automatic pix_t convert_pixel(int s);
    pix_t   p;
    longint prod, d;
    u64_t   v;
    p.pixel = 0;
    p.empty = 0;
    if (r_mode == MODE_TRUNC) begin
      if (s < 0) p.pixel = 0;
      else if (s > 65280) p.pixel = 255;
      else p.pixel = 8'((s + 128) >> 8);
    end else if (r_mode == MODE_FIXED) begin
      prod = longint'(s) * longint'(r_factor);
      if (prod >= 0) begin
        v = u64_t'(prod) >> 24;
        p.pixel = (v > 255) ? 8'd255 : 8'(v);
      end
    end else if (st_slope == 0) begin
      p.empty = 1;
    end else begin
      d = longint'(s) - st_floor;
      if (d >= 0) begin
        v = (u64_t'(d) * st_slope) >> 24;
        p.pixel = (v > 255) ? 8'd255 : 8'(v);
      end
    end
    return p;
  endfunction

  // update the shadow state for one accepted input beat
  function automatic void absorb_beat(beat_t b);
    int s;
    bit skip;
    s = int'(b.s);
    if (b.conv) begin
      pix_q.push_back(convert_pixel(s));
      return;
    end
    if (fresh) begin
      lo_seen = 8388607;
      hi_seen = -8388608;
      acc_sum = 0;
      acc_sq = 0;
      n_counted = 0;
      fresh = 0;
    end
    skip = (r_mode == MODE_SIGMA) ? (s == 0) : (r_mask_en && s == r_mask_val);
    if (!skip && n_counted < CAP) begin
      if (s < lo_seen) lo_seen = s;
      if (s > hi_seen) hi_seen = s;
      acc_sum += s;
      acc_sq += u64_t'(longint'(s) * longint'(s));
      n_counted++;
    end
    if (b.lst) begin
      derive_bounds();
      fresh = 1;
    end
  endfunction

  // clock, timeout
  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  initial begin
    #80_000_000;
    $display("simulation failed");
    $finish;
  end

  // input driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) absorb_beat(cur_beat);
      if (!in_tvalid || in_tready) begin
        if (beat_q.size() > 0 && (calm || $urandom_range(0, 99) >= 12)) begin
          cur_beat = beat_q.pop_front();
          in_tvalid <= 1'b1;
          in_tdata  <= cur_beat.s;
          in_tuser  <= cur_beat.conv;
          in_tlast  <= cur_beat.lst;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  task automatic note_bad(string msg);
    errors++;
    if (errors <= 10) $display("mismatch at %0t: %s", $realtime, msg);
  endtask

  // long receiver hold-off, counted in cycles
  always @(posedge clk) begin
    if (hold_req) begin
      hold_req = 0;
      stall_left = 400;
    end else if (stall_left > 0) begin
      stall_left--;
    end
    hold_off <= (stall_left > 0);
  end

  // output monitor and receiver stalls
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (pix_q.size() == 0) begin
          note_bad($sformatf("unexpected beat pixel %0d empty %0d", out_tdata, out_tuser));
        end else begin
          pix_t e;
          e = pix_q.pop_front();
          if (out_tdata !== e.pixel)
            note_bad($sformatf("pixel exp %0d got %0d", e.pixel, out_tdata));
          if (out_tuser !== e.empty)
            note_bad($sformatf("range_empty exp %0d got %0d", e.empty, out_tuser));
        end
      end
      if (hold_off) begin
        out_tready <= 1'b0;
      end else begin
        out_tready <= calm || $urandom_range(0, 99) >= 12;
      end
    end
  end

  function automatic void add(bit conv, int s, bit lst = 0);
    beat_t b;
    b.conv = conv;
    b.s = s[SAMPLE_W-1:0];
    b.lst = lst;
    beat_q.push_back(b);
    fed++;
  endfunction

  // everything accepted and drained, plus room for a bound computation
  task automatic wait_idle();
    while (beat_q.size() > 0 || in_tvalid || pix_q.size() > 0) @(posedge clk);
    repeat (300) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] addr, int data);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_addr  <= addr;
    cfg_wdata <= data[CFG_W-1:0];
    @(posedge clk);
    cfg_we <= 1'b0;
    case (addr)
      REG_SCALE_MODE: r_mode = data[1:0];
      REG_MASK_EN:    r_mask_en = data[0];
      REG_MASK_VAL:   r_mask_val = int'(signed'(data[SAMPLE_W-1:0]));
      REG_FACTOR:     r_factor = data[CFG_W-1:0];
      default: ;
    endcase
  endtask

  task automatic set_cfg(logic [1:0] md, bit men, int mval, int fac);
    write_reg(REG_SCALE_MODE, int'(md));
    write_reg(REG_MASK_EN, int'(men));
    write_reg(REG_MASK_VAL, mval);
    write_reg(REG_FACTOR, fac);
  endtask

  function automatic int pick_sample(int center, int span);
    case ($urandom_range(0, 9))
      0: return int'(signed'(24'($urandom())));
      1: return $urandom_range(0, 1) ? 8388607 : -8388608;
      default: return center + int'($urandom_range(0, 2 * span)) - span;
    endcase
  endfunction

  // stimulus
  initial begin
    int center, span, glen, clen, mval, fac;
    logic [1:0] md;
    bit men, sel;

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // truncate mode at reset defaults: clamps and rounding edges
    add(1, 0); add(1, -1); add(1, -8388608); add(1, 8388607); add(1, 127);
    add(1, 128); add(1, 383); add(1, 65280); add(1, 65281, 1);
    wait_idle();

    // stretch convert before any gather pass gives an empty range
    set_cfg(MODE_MINMAX, 1, 1000, FACTOR_RST);
    add(1, 500);
    // min-max with a masked sample
    add(0, 1000); add(0, 0); add(0, 25600, 1);
    add(1, -5); add(1, 12800); add(1, 25600); add(1, 30000);
    wait_idle();

    // two-sigma skips zero samples
    set_cfg(MODE_SIGMA, 0, 0, FACTOR_RST);
    add(0, 0); add(0, 256); add(0, 512); add(0, 768); add(0, 10000, 1);
    add(1, 300); add(1, 900);
    wait_idle();

    // zero range, then mode switch keeps old bounds
    set_cfg(MODE_MINMAX, 0, 0, 24'hFFFFFF);
    add(0, 500); add(0, 500, 1); add(1, 500);
    wait_idle();
    write_reg(REG_SCALE_MODE, int'(MODE_FIXED));
    add(1, 1); add(1, -1); add(1, 300);
    wait_idle();
    write_reg(REG_FACTOR, 0);
    add(1, 8388607);
    wait_idle();

    // full-scale range between the sample extremes
    set_cfg(MODE_MINMAX, 0, 0, FACTOR_RST);
    add(0, 12345); add(0, -8388608); add(0, 8388607, 1);
    add(1, -8388608); add(1, 0); add(1, -1); add(1, 8388607); add(1, 8388606);
    wait_idle();

    // random passes: gather then convert, with some broken sequences
    for (int ph = 0; fed < 1900; ph++) begin
      md = 2'($urandom_range(0, 3));
      men = 1'($urandom_range(0, 1));
      case ($urandom_range(0, 3))
        0: begin center = int'(signed'(24'($urandom()))); span = 4000000; end
        1: begin center = $urandom_range(0, 70000); span = $urandom_range(0, 30000); end
        2: begin center = 0; span = $urandom_range(0, 600); end
        default: begin center = int'($urandom_range(0, 2000000)) - 1000000; span = 50; end
      endcase
      mval = $urandom_range(0, 1) ? center : int'(signed'(24'($urandom())));
      case ($urandom_range(0, 4))
        0: fac = 0;
        1: fac = 24'hFFFFFF;
        2: fac = FACTOR_RST;
        3: fac = $urandom_range(0, 300000);
        default: fac = $urandom_range(0, 24'hFFFFFF);
      endcase
      set_cfg(md, men, mval, fac);
      calm = (ph >= 6 && ph < 10);

      case ($urandom_range(0, 9))
        0: glen = 0;
        1: glen = 1;
        default: glen = $urandom_range(2, 60);
      endcase
      sel = $urandom_range(0, 9) != 0;
      for (int i = 0; i < glen; i++) begin
        case ($urandom_range(0, 7))
          0: add(0, mval, sel && i == glen - 1);
          1: add(0, 0, sel && i == glen - 1);
          default: add(0, pick_sample(center, span), sel && i == glen - 1);
        endcase
      end
      clen = $urandom_range(10, 50);
      for (int i = 0; i < clen; i++) begin
        if ($urandom_range(0, 32) == 0) add(0, pick_sample(center, span), 0);
        else add(1, pick_sample(center, span + 256), 1'($urandom_range(0, 1)));
      end
      if (ph == 3 || ph == 12) hold_req = 1;
      wait_idle();
    end
    calm = 0;

    wait_idle();
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
